@@ src/irlbq_pkg.sv @@
// Package for the IR light bar level qualifier: class codes, register
// indexes, default widths and reset values of the configuration registers.
// No dependencies.
package irlbq_pkg;

    localparam int SAMPLE_BITS_DEF = 10;
    localparam int AVG_SHIFT_DEF   = 4;
    localparam int COUNT_BITS      = 8;
    localparam int CFG_IDX_BITS    = 2;

    localparam int OPEN_THR_RST  = 500;
    localparam int CLOSE_THR_RST = 200;
    localparam int RISE_CNT_RST  = 2;
    localparam int FALL_CNT_RST  = 100;

    typedef enum logic [1:0] {
        CLASS_OPEN   = 2'd0,
        CLASS_CLOSED = 2'd1,
        CLASS_ERROR  = 2'd2
    } t_class;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_OPEN_THR  = 2'd0,
        CFG_CLOSE_THR = 2'd1,
        CFG_RISE_CNT  = 2'd2,
        CFG_FALL_CNT  = 2'd3
    } t_cfg_idx;

endpackage

@@ src/irlbq_in_if.sv @@
// Sample channel: valid/ready handshake carrying one ADC sample.
// Depends on irlbq_pkg for the default sample width.
interface irlbq_in_if #(
    parameter int SAMPLE_BITS = irlbq_pkg::SAMPLE_BITS_DEF
) ();
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

@@ src/irlbq_out_if.sv @@
// Result channel: valid/ready handshake carrying the classification and
// the running base average. Depends on irlbq_pkg for the class type.
interface irlbq_out_if #(
    parameter int SAMPLE_BITS = irlbq_pkg::SAMPLE_BITS_DEF
) ();
    logic                   valid;
    logic                   ready;
    irlbq_pkg::t_class      raw_class;
    irlbq_pkg::t_class      stable_class;
    logic                   changed;
    logic [SAMPLE_BITS-1:0] base_average;

    modport source (output valid, output raw_class, output stable_class,
                    output changed, output base_average, input ready);
    modport sink   (input valid, input raw_class, input stable_class,
                    input changed, input base_average, output ready);
endinterface

@@ src/ir_light_bar_level_qualifier_core.sv @@
// Top level of the IR light bar level qualifier: input register, evaluation
// stage and result register, plus the configuration registers.
// Depends on irlbq_pkg, irlbq_in_if, irlbq_out_if and irlbq_eval.
//
//   channel   direction  payload                                        accepted when
//   i_in      in         sample                                         valid && ready
//   o_out     out        raw_class, stable_class, changed, base_average valid && ready
//   i_cfg_*   in         index, data                                    i_cfg_we
//
// One transaction per cycle is sustained while o_out is not stalled; a sample accepted
// into the input register is evaluated combinationally and loaded into the result register
// once that register is free or being emptied, and its result is then offered on o_out.
// Synchronous active-low reset empties both stages, clears the average, debounce
// counter and stable class (open) and reloads the register defaults.
// While the result is held by a stalled sink, the input register still takes
// one more transaction; the pipe stops only when both are full.
module ir_light_bar_level_qualifier_core #(
    parameter int SAMPLE_BITS = irlbq_pkg::SAMPLE_BITS_DEF,
    parameter int AVG_SHIFT   = irlbq_pkg::AVG_SHIFT_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    irlbq_in_if.sink                           i_in,
    irlbq_out_if.source                        o_out,
    input  logic                               i_cfg_we,
    input  logic [irlbq_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [SAMPLE_BITS-1:0]             i_cfg_data
);
    import irlbq_pkg::*;

    // configuration registers
    logic [SAMPLE_BITS-1:0] r_open_thr;
    logic [SAMPLE_BITS-1:0] r_close_thr;
    logic [COUNT_BITS-1:0]  r_rise_cnt;
    logic [COUNT_BITS-1:0]  r_fall_cnt;

    // input register
    logic                   r_s1_valid;
    logic [SAMPLE_BITS-1:0] r_s1_sample;

    // result register
    logic                   r_out_valid;
    t_class                 r_out_raw;
    t_class                 r_out_stable;
    logic                   r_out_changed;
    logic [SAMPLE_BITS-1:0] r_out_avg;

    logic                   w_advance;
    logic                   w_in_accept;
    logic                   w_step;
    t_class                 w_raw;
    t_class                 w_stable;
    logic                   w_changed;
    logic [SAMPLE_BITS-1:0] w_avg;

    // Advance the evaluation stage whenever the result register is free or
    // being emptied; take a new sample whenever the input register will be free.
    assign w_advance   = !r_out_valid || o_out.ready;
    assign w_step      = r_s1_valid && w_advance;
    assign i_in.ready  = !r_s1_valid || w_advance;
    assign w_in_accept = i_in.valid && i_in.ready;

    // Register writes; the user must make these only while the block is idle, which the block itself does not enforce.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_thr  <= SAMPLE_BITS'(OPEN_THR_RST);
            r_close_thr <= SAMPLE_BITS'(CLOSE_THR_RST);
            r_rise_cnt  <= COUNT_BITS'(RISE_CNT_RST);
            r_fall_cnt  <= COUNT_BITS'(FALL_CNT_RST);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_OPEN_THR:  r_open_thr  <= i_cfg_data;
                CFG_CLOSE_THR: r_close_thr <= i_cfg_data;
                CFG_RISE_CNT:  r_rise_cnt  <= i_cfg_data[COUNT_BITS-1:0];
                CFG_FALL_CNT:  r_fall_cnt  <= i_cfg_data[COUNT_BITS-1:0];
            endcase
        end
    end

    // Input register: fill on accept, drop when the sample moves on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_s1_sample <= i_in.sample;
        end
    end

    irlbq_eval #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .AVG_SHIFT   (AVG_SHIFT)
    ) u_eval (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (w_step),
        .i_sample       (r_s1_sample),
        .i_open_thr     (r_open_thr),
        .i_close_thr    (r_close_thr),
        .i_rise_cnt     (r_rise_cnt),
        .i_fall_cnt     (r_fall_cnt),
        .o_raw_class    (w_raw),
        .o_stable_class (w_stable),
        .o_changed      (w_changed),
        .o_base_average (w_avg)
    );

    // Result register: load on each step, hold while the sink stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_raw     <= w_raw;
            r_out_stable  <= w_stable;
            r_out_changed <= w_changed;
            r_out_avg     <= w_avg;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.raw_class    = r_out_raw;
    assign o_out.stable_class = r_out_stable;
    assign o_out.changed      = r_out_changed;
    assign o_out.base_average = r_out_avg;

endmodule

@@ src/irlbq_eval.sv @@
// Per-sample evaluation: running average, window classification and
// asymmetric debounce, with the state they keep. Depends on irlbq_pkg.
module irlbq_eval #(
    parameter int SAMPLE_BITS = irlbq_pkg::SAMPLE_BITS_DEF,
    parameter int AVG_SHIFT   = irlbq_pkg::AVG_SHIFT_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_step,
    input  logic [SAMPLE_BITS-1:0]           i_sample,
    input  logic [SAMPLE_BITS-1:0]           i_open_thr,
    input  logic [SAMPLE_BITS-1:0]           i_close_thr,
    input  logic [irlbq_pkg::COUNT_BITS-1:0] i_rise_cnt,
    input  logic [irlbq_pkg::COUNT_BITS-1:0] i_fall_cnt,
    output irlbq_pkg::t_class                o_raw_class,
    output irlbq_pkg::t_class                o_stable_class,
    output logic                             o_changed,
    output logic [SAMPLE_BITS-1:0]           o_base_average
);
    import irlbq_pkg::*;

    localparam int AccW = SAMPLE_BITS + AVG_SHIFT + 1;

    logic [SAMPLE_BITS-1:0] r_avg;
    logic [SAMPLE_BITS-1:0] n_avg;
    t_class                 r_stable;
    t_class                 n_stable;
    logic [COUNT_BITS-1:0]  r_cnt;
    logic [COUNT_BITS-1:0]  n_cnt;

    logic [AccW-1:0]        w_acc;
    t_class                 w_raw;
    logic [COUNT_BITS-1:0]  w_cnt_inc;
    logic [COUNT_BITS-1:0]  w_target;
    logic                   w_differ;
    logic                   w_hit;

    // base*(2^shift - 1) + sample, then drop the low bits
    always_comb begin
        w_acc = (AccW'(r_avg) << AVG_SHIFT) - AccW'(r_avg) + AccW'(i_sample);
        n_avg = w_acc[AVG_SHIFT +: SAMPLE_BITS];
    end

    // open test wins when the thresholds overlap
    always_comb begin
        if (i_sample > i_open_thr) begin
            w_raw = CLASS_OPEN;
        end else if (i_sample <= i_close_thr) begin
            w_raw = CLASS_CLOSED;
        end else begin
            w_raw = CLASS_ERROR;
        end
    end

    always_comb begin
        w_differ  = (w_raw != r_stable);
        w_cnt_inc = r_cnt + COUNT_BITS'(1);
        w_target  = (w_raw == CLASS_OPEN) ? i_rise_cnt : i_fall_cnt;
        w_hit     = w_differ && (w_cnt_inc == w_target);
        n_stable  = w_hit ? w_raw : r_stable;
        n_cnt     = (!w_differ || w_hit) ? '0 : w_cnt_inc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg    <= '0;
            r_stable <= CLASS_OPEN;
            r_cnt    <= '0;
        end else if (i_step) begin
            r_avg    <= n_avg;
            r_stable <= n_stable;
            r_cnt    <= n_cnt;
        end
    end

    assign o_raw_class    = w_raw;
    assign o_stable_class = n_stable;
    assign o_changed      = w_hit;
    assign o_base_average = n_avg;

endmodule

@@ src/irlbq_checker.sv @@
// Port-level checks for the IR light bar level qualifier, bound to the top
// level. Depends on irlbq_pkg and ir_light_bar_level_qualifier_core.
module irlbq_checker #(
    parameter int SAMPLE_BITS = irlbq_pkg::SAMPLE_BITS_DEF
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   i_in_ready,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input irlbq_pkg::t_class      i_out_raw,
    input irlbq_pkg::t_class      i_out_stable,
    input logic                   i_out_changed,
    input logic [SAMPLE_BITS-1:0] i_out_avg
);
    import irlbq_pkg::*;

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_raw)
            && $stable(i_out_stable) && $stable(i_out_changed) && $stable(i_out_avg))
        else $error("result changed while stalled");

    // an adopted class is the class of that very sample
    a_change_adopts_raw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_changed |-> i_out_stable == i_out_raw)
        else $error("stable class update does not match raw class");

    // reset empties the pipe: no result in the cycle after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // input side never refuses while the output side is taking data
    a_ready_when_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> i_in_ready)
        else $error("input stalled although the result is being taken");

endmodule

bind ir_light_bar_level_qualifier_core irlbq_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_irlbq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_raw     (o_out.raw_class),
    .i_out_stable  (o_out.stable_class),
    .i_out_changed (o_out.changed),
    .i_out_avg     (o_out.base_average)
);

@@ sim/tb_ir_light_bar_level_qualifier_core.sv @@
// Testbench for ir_light_bar_level_qualifier_core: streams ADC samples through the
// sample channel, predicts class, debounced class and base average per sample, and
// checks each result transaction. Depends on irlbq_pkg, irlbq_in_if and irlbq_out_if.
module tb_ir_light_bar_level_qualifier_core;
    import irlbq_pkg::*;

    localparam int SB          = SAMPLE_BITS_DEF;
    localparam int CYCLE_LIMIT = 600000;
    localparam int RANDOM_ITEMS = 520;

    // One expected result transaction.
    typedef struct packed {
        t_class        raw_class;
        t_class        stable_class;
        logic          changed;
        logic [SB-1:0] base_average;
    } t_level;

    logic          i_clk = 1'b0;
    logic          i_rst_n;
    logic          cfg_we;
    t_cfg_idx      cfg_idx;
    logic [SB-1:0] cfg_data;

    irlbq_in_if  #(.SAMPLE_BITS(SB)) in_ch ();
    irlbq_out_if #(.SAMPLE_BITS(SB)) out_ch ();

    ir_light_bar_level_qualifier_core #(
        .SAMPLE_BITS(SB),
        .AVG_SHIFT  (AVG_SHIFT_DEF)
    ) u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_ch.sink),
        .o_out     (out_ch.source),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor copy of the configuration registers.
    logic [SB-1:0]         open_thr;
    logic [SB-1:0]         close_thr;
    logic [COUNT_BITS-1:0] rise_cnt;
    logic [COUNT_BITS-1:0] fall_cnt;

    // Predictor copy of the running state.
    logic [SB-1:0]         avg_level;
    t_class                settled_class;
    logic [COUNT_BITS-1:0] persist_cnt;

    logic [SB-1:0] sample_backlog[$];   // samples waiting to be offered
    t_level        pending_levels[$];   // predicted results, oldest first

    int  samples_queued;
    int  samples_accepted;
    int  results_checked;
    int  mismatch_count;
    int  cycle_count;
    int  send_gap;
    int  take_gap;
    bit  send_idle;
    bit  take_idle;
    bit  sink_hold;

    // Advance the predictor by one sample and return the result it implies.
    function automatic t_level qualify_sample(logic [SB-1:0] s);
        t_level                r;
        int unsigned           acc;
        logic [COUNT_BITS-1:0] goal;
        acc       = avg_level * ((1 << AVG_SHIFT_DEF) - 1) + s;
        avg_level = SB'(acc >> AVG_SHIFT_DEF);
        // The open test wins when the thresholds overlap.
        if (s > open_thr) begin
            r.raw_class = CLASS_OPEN;
        end else if (s <= close_thr) begin
            r.raw_class = CLASS_CLOSED;
        end else begin
            r.raw_class = CLASS_ERROR;
        end
        r.changed = 1'b0;
        if (r.raw_class != settled_class) begin
            // Keep counting across a switch between two non-stable classes; the
            // 8-bit count wraps, so an overshoot waits for the next wrap.
            persist_cnt = persist_cnt + 1'b1;
            goal = (r.raw_class == CLASS_OPEN) ? rise_cnt : fall_cnt;
            if (persist_cnt == goal) begin
                settled_class = r.raw_class;
                persist_cnt   = '0;
                r.changed     = 1'b1;
            end
        end else begin
            persist_cnt = '0;
        end
        r.stable_class = settled_class;
        r.base_average = avg_level;
        return r;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Draw a sample that falls in the wanted class under the current thresholds,
    // leaning on the class edges; a tenth of the draws are plain noise.
    function automatic logic [SB-1:0] sample_in_class(t_class want);
        int lo;
        int hi;
        int r;
        case (want)
            CLASS_OPEN: begin
                lo = open_thr + 1;
                hi = (1 << SB) - 1;
            end
            CLASS_CLOSED: begin
                lo = 0;
                hi = close_thr;
            end
            default: begin
                lo = close_thr + 1;
                hi = open_thr;
            end
        endcase
        r = $urandom_range(0, 19);
        if (lo > hi || r < 2) return SB'($urandom);
        if (r < 5) return SB'(lo);
        if (r < 8) return SB'(hi);
        return SB'($urandom_range(hi, lo));
    endfunction

    function automatic logic [SB-1:0] pick_thr();
        int r;
        r = $urandom_range(0, 19);
        if (r < 3) return '0;
        if (r < 6) return '1;
        return SB'($urandom);
    endfunction

    function automatic logic [COUNT_BITS-1:0] pick_count();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 8'd1;
        if (r == 1) return 8'd255;
        if (r < 8) return COUNT_BITS'($urandom_range(1, 6));
        return COUNT_BITS'($urandom_range(1, 40));
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        mismatch_count++;
        if (mismatch_count <= 100)
            $display("mismatch at result %0d: %s got %0d expected %0d",
                     results_checked, what, got, want);
    endtask

    task automatic push_sample(logic [SB-1:0] s);
        sample_backlog.push_back(s);
        samples_queued++;
    endtask

    // Hold until every queued sample is accepted and every result is back, then
    // let both stages of the pipe settle, plus margin.
    task automatic wait_drained();
        while (samples_accepted != samples_queued || pending_levels.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [SB-1:0] data);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        case (idx)
            CFG_OPEN_THR:  open_thr  = data;
            CFG_CLOSE_THR: close_thr = data;
            CFG_RISE_CNT:  rise_cnt  = data[COUNT_BITS-1:0];
            CFG_FALL_CNT:  fall_cnt  = data[COUNT_BITS-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Drain, then load all four registers. Counts carry random upper data bits,
    // which the 8-bit registers drop.
    task automatic set_levels(logic [SB-1:0] open_v, logic [SB-1:0] close_v,
                              logic [COUNT_BITS-1:0] rise_v,
                              logic [COUNT_BITS-1:0] fall_v);
        logic [SB-1:0] d;
        wait_drained();
        write_reg(CFG_OPEN_THR, open_v);
        write_reg(CFG_CLOSE_THR, close_v);
        d = SB'($urandom);
        d[COUNT_BITS-1:0] = rise_v;
        write_reg(CFG_RISE_CNT, d);
        d = SB'($urandom);
        d[COUNT_BITS-1:0] = fall_v;
        write_reg(CFG_FALL_CNT, d);
    endtask

    // Sample driver: predict on each accepted transaction, then offer the next
    // sample from the backlog after an optional gap.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                pending_levels.push_back(qualify_sample(in_ch.sample));
                samples_accepted++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_ch.valid <= 1'b0;
                end else if (sample_backlog.size() != 0) begin
                    in_ch.valid  <= 1'b1;
                    in_ch.sample <= sample_backlog.pop_front();
                    send_gap = send_idle ? pick_gap() : 0;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare each accepted transaction against the oldest
    // prediction, field by field, and pace ready with random stalls.
    always @(posedge i_clk) begin
        t_level want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            take_gap = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                results_checked++;
                if (pending_levels.size() == 0) begin
                    report_mismatch("result with none pending", 1, 0);
                end else begin
                    want = pending_levels.pop_front();
                    if (out_ch.raw_class !== want.raw_class)
                        report_mismatch("raw_class", out_ch.raw_class, want.raw_class);
                    if (out_ch.stable_class !== want.stable_class)
                        report_mismatch("stable_class", out_ch.stable_class,
                                        want.stable_class);
                    if (out_ch.changed !== want.changed)
                        report_mismatch("changed", out_ch.changed, want.changed);
                    if (out_ch.base_average !== want.base_average)
                        report_mismatch("base_average", out_ch.base_average,
                                        want.base_average);
                end
            end
            if (sink_hold) begin
                out_ch.ready <= 1'b0;
            end else if (take_gap > 0) begin
                take_gap--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                take_gap = take_idle ? pick_gap() : 0;
            end
        end
    end

    // Watchdog: give up if the run hangs.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL ir_light_bar_level_qualifier_core");
            $finish;
        end
    end

    initial begin
        int     random_sent;
        int     phase;
        int     goal;
        int     burst;
        int     need;
        t_class want;

        // Drive every input to a known value before the first edge.
        i_rst_n      = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = CFG_OPEN_THR;
        cfg_data     = '0;
        in_ch.valid  = 1'b0;
        in_ch.sample = '0;
        out_ch.ready = 1'b0;
        sink_hold    = 1'b0;
        send_idle    = 1'b0;
        take_idle    = 1'b0;

        open_thr      = SB'(OPEN_THR_RST);
        close_thr     = SB'(CLOSE_THR_RST);
        rise_cnt      = COUNT_BITS'(RISE_CNT_RST);
        fall_cnt      = COUNT_BITS'(FALL_CNT_RST);
        avg_level     = '0;
        settled_class = CLASS_OPEN;
        persist_cnt   = '0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset defaults: sample extremes, both threshold edges, alternating bits.
        push_sample(10'd0);
        push_sample(10'd1023);
        push_sample(10'd500);
        push_sample(10'd501);
        push_sample(10'd200);
        push_sample(10'd201);
        push_sample(10'h155);
        push_sample(10'h2AA);

        // Short debounce: adopt closed, hop error -> open without a clear,
        // then error -> closed, then back to open.
        set_levels(10'd600, 10'd300, 8'd2, 8'd2);
        push_sample(10'd100);
        push_sample(10'd100);
        push_sample(10'd400);
        push_sample(10'd700);
        push_sample(10'd1023);
        push_sample(10'd450);
        push_sample(10'd0);
        push_sample(10'd601);
        push_sample(10'd900);

        // Overlapping thresholds: anything above open stays open.
        set_levels(10'd300, 10'd700, 8'd1, 8'd1);
        push_sample(10'd301);
        push_sample(10'd700);
        push_sample(10'd300);
        push_sample(10'd0);
        push_sample(10'd1023);

        // Count overshoot: three open ticks carry the count past a fall count of
        // two, so the error run is adopted only after the 8-bit count wraps.
        set_levels(10'd600, 10'd300, 8'd5, 8'd2);
        push_sample(10'd50);
        push_sample(10'd50);
        repeat (3) push_sample(10'd800);
        repeat (260) push_sample(SB'($urandom_range(450, 301)));

        // Random phases of class bursts sized around the debounce counts.
        random_sent = 0;
        phase       = 0;
        while (random_sent < RANDOM_ITEMS) begin
            case (phase)
                0:       set_levels('1, '0, 8'd255, 8'd1);
                1:       set_levels('0, '1, 8'd1, 8'd255);
                default: set_levels(pick_thr(), pick_thr(), pick_count(), pick_count());
            endcase
            send_idle = ($urandom_range(0, 3) != 0);
            take_idle = ($urandom_range(0, 3) != 0);
            goal = random_sent + $urandom_range(40, 120);
            while (random_sent < goal) begin
                want = t_class'($urandom_range(0, 2));
                need = (want == CLASS_OPEN) ? rise_cnt : fall_cnt;
                if (need <= 20 || $urandom_range(0, 9) < 3)
                    burst = $urandom_range(need + 2, (need > 2) ? need - 2 : 1);
                else
                    burst = $urandom_range(1, 8);
                repeat (burst) begin
                    push_sample(sample_in_class(want));
                    random_sent++;
                end
            end
            // Stall the result side long enough to fill both stages and block input.
            if (phase == 0) begin
                @(posedge i_clk);
                sink_hold <= 1'b1;
                repeat (80) @(posedge i_clk);
                sink_hold <= 1'b0;
            end
            phase++;
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("PASS ir_light_bar_level_qualifier_core");
        else
            $display("FAIL ir_light_bar_level_qualifier_core");
        $finish;
    end

endmodule
